// ===== rtl/prin_pkg.sv =====
// Package for the point range image normalizer.
// Field widths, register indexes and shared structs. No dependencies.
package prin_pkg;

  localparam int COORD_W = 16;
  localparam int RANGE_W = 16;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 32;
  localparam int PIX_W   = 26;
  localparam int INDEX_W = 16;
  localparam int FRAC_W  = 6;
  localparam int FIT_W   = 8;

  localparam logic [RANGE_W-1:0] MIN_RESET = '1;
  localparam logic [FIT_W-1:0]   FIT_FULL  = '1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64);

  // configuration register indexes
  localparam logic [0:0] CFG_FIT_MODE = 1'b0;
  localparam logic [0:0] CFG_SCALE    = 1'b1;

  typedef struct packed {
    logic               invalid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } prin_pt_t;

  typedef struct packed {
    logic [RANGE_W-1:0] diff;
    logic [RANGE_W-1:0] span;
  } prin_div_req_t;

endpackage

// ===== rtl/prin_in_if.sv =====
// Input channel: one load point or one pixel read per item.
// Depends on prin_pkg.
interface prin_in_if import prin_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic               first_point;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] z_coord;
  logic               point_invalid;
  logic [INDEX_W-1:0] pixel_index;

  modport source (output valid, mode, first_point, x_coord, y_coord, z_coord,
                  point_invalid, pixel_index, input ready);
  modport sink   (input valid, mode, first_point, x_coord, y_coord, z_coord,
                  point_invalid, pixel_index, output ready);
endinterface

// ===== rtl/prin_out_if.sv =====
// Output channel: one pixel result per read item.
// Depends on prin_pkg.
interface prin_out_if import prin_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             index_unwritten;

  modport source (output valid, pixel_value, index_unwritten, input ready);
  modport sink   (input valid, pixel_value, index_unwritten, output ready);
endinterface

// ===== rtl/prin_range.sv =====
// Range unit: sum of squares on one shared multiplier, then a restoring
// bit-serial square root. Depends on prin_pkg.
module prin_range import prin_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  prin_pt_t           pt,
  output logic               done,
  output logic [RANGE_W-1:0] range_out
);

  localparam int SQ_STEPS   = 4;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int LAST       = SQ_STEPS + ROOT_STEPS - 1;
  localparam int PH_W       = $clog2(LAST + 1);
  localparam int REM_W      = RANGE_W + 1;
  localparam int OPS_W      = 3 * COORD_W;

  logic                busy;
  logic [PH_W-1:0]     phase;
  logic [OPS_W-1:0]    ops;
  logic [SUM_W-1:0]    prod;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [RANGE_W-1:0]  root;

  logic [COORD_W-1:0]  ax, ay, az, op0;
  logic [SUM_W-1:0]    acc_next;
  logic [REM_W+1:0]    rem_t, trial;
  logic                ge;

  assign ax  = pt.x[COORD_W-1] ? COORD_W'(-pt.x) : pt.x;
  assign ay  = pt.y[COORD_W-1] ? COORD_W'(-pt.y) : pt.y;
  assign az  = pt.z[COORD_W-1] ? COORD_W'(-pt.z) : pt.z;
  assign op0 = ops[OPS_W-1 -: COORD_W];

  assign acc_next = acc + prod;
  assign rem_t    = {rem, rad[SUM_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign ge       = rem_t >= trial;

  assign range_out = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
        ops   <= pt.invalid ? '0 : {ax, ay, az};
        prod  <= '0;
        acc   <= '0;
      end else if (busy) begin
        phase <= phase + PH_W'(1);
        if (phase < PH_W'(SQ_STEPS)) begin
          prod <= SUM_W'(op0 * op0);
          ops  <= ops << COORD_W;
          acc  <= acc_next;
          if (phase == PH_W'(SQ_STEPS - 1)) begin
            rad  <= acc_next;
            rem  <= '0;
            root <= '0;
          end
        end else begin
          rad  <= rad << 2;
          rem  <= ge ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
          root <= {root[RANGE_W-2:0], ge};
          if (phase == PH_W'(LAST)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/prin_div.sv =====
// Fit-mode divider: floor(diff*255/span), one quotient bit per cycle.
// Requires diff < span. Depends on prin_pkg.
module prin_div import prin_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  prin_div_req_t     req,
  output logic              done,
  output logic [FIT_W-1:0]  quo
);

  localparam int NUM_W = RANGE_W + FIT_W;
  localparam int CNT_W = $clog2(FIT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  den_sh;
  logic [NUM_W-1:0]  diff_w;
  logic              ge;

  assign diff_w = NUM_W'(req.diff);
  assign ge     = num >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        num    <= (diff_w << FIT_W) - diff_w;
        den_sh <= NUM_W'(req.span) << (FIT_W - 1);
        quo    <= '0;
      end else if (busy) begin
        cnt    <= cnt + CNT_W'(1);
        num    <= ge ? num - den_sh : num;
        den_sh <= den_sh >> 1;
        quo    <= {quo[FIT_W-2:0], ge};
        if (cnt == CNT_W'(FIT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/point_range_image_normalizer.sv =====
// Top level: frame store, min/max tracking, read scaling and control.
// Depends on prin_pkg, prin_in_if, prin_out_if, prin_range, prin_div.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    mode first_point x/y/z_coord point_invalid pixel_index
//   rsp      out  valid/ready    pixel_value index_unwritten
//   cfg      in   cfg_we         cfg_index cfg_data
//
// One item at a time. A load runs the squaring multiplier, then the serial square
// root, then writes the store. A plain read steps through ST_RD_ADDR, ST_RD_DATA
// and ST_PUT; an unwritten index goes straight to ST_PUT; a fit-mode read may also
// wait for the divider in ST_DIV_WAIT. Results sit in an output register; the next
// item is taken while it waits. A finished read waits for that register to empty.
// Reset is synchronous; the frame store is not cleared.
module point_range_image_normalizer import prin_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  prin_in_if.sink            req,
  prin_out_if.source         rsp,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [SCALE_W-1:0] cfg_data
);

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_RD_ADDR, ST_RD_DATA, ST_DIV_WAIT, ST_PUT
  } state_t;

  state_t               state;
  logic                 fit_mode;
  logic [SCALE_W-1:0]   scale_q6;
  logic [CW-1:0]        count;
  logic [RANGE_W-1:0]   min_range;
  logic [RANGE_W-1:0]   max_range;
  logic [AW-1:0]        rd_addr;
  logic [RANGE_W-1:0]   rd_data;
  logic [PIX_W-1:0]     res_value;
  logic                 res_unwr;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_value;
  logic                 out_unwr;

  logic [RANGE_W-1:0]   store [MAX_POINTS];

  logic                 accept;
  logic [CW-1:0]        eff_count;
  logic                 drop;
  logic [IW-1:0]        idx_w;
  logic                 hit;
  logic                 rng_start, rng_done;
  logic [RANGE_W-1:0]   rng_value;
  prin_pt_t             pt;
  logic                 div_start, div_done;
  logic [FIT_W-1:0]     div_quo;
  prin_div_req_t        div_req;
  logic                 mem_we;
  logic [SUM_W-1:0]     plain_prod;
  logic                 put_ok;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign eff_count = req.first_point ? '0 : count;
  assign drop      = (eff_count == CW'(MAX_POINTS));
  assign idx_w     = IW'(req.pixel_index);
  assign hit       = (idx_w < IW'(count)) && (idx_w < IW'(MAX_POINTS));

  assign pt        = '{invalid: req.point_invalid, x: req.x_coord,
                       y: req.y_coord, z: req.z_coord};
  assign rng_start = accept && !req.mode && !drop;
  assign mem_we    = (state == ST_LOAD) && rng_done;

  assign div_req   = '{diff: rd_data - min_range, span: max_range - min_range};
  assign div_start = (state == ST_RD_DATA) && fit_mode && (max_range > min_range) &&
                     (rd_data > min_range) && (rd_data < max_range);

  assign plain_prod = SUM_W'(rd_data * scale_q6);
  assign put_ok     = !out_valid || rsp.ready;

  assign rsp.valid           = out_valid;
  assign rsp.pixel_value     = out_value;
  assign rsp.index_unwritten = out_unwr;

  prin_range u_range (
    .clk       (clk),
    .rst       (rst),
    .start     (rng_start),
    .pt        (pt),
    .done      (rng_done),
    .range_out (rng_value)
  );

  prin_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[count[AW-1:0]] <= rng_value;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fit_mode  <= 1'b0;
      scale_q6  <= SCALE_RESET;
      count     <= '0;
      min_range <= MIN_RESET;
      max_range <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIT_MODE: fit_mode <= cfg_data[0];
          CFG_SCALE:    scale_q6 <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && rsp.ready && (state != ST_PUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!req.mode) begin
              if (req.first_point) begin
                count     <= '0;
                min_range <= MIN_RESET;
                max_range <= '0;
              end
              if (!drop) begin
                state <= ST_LOAD;
              end
            end else if (hit) begin
              rd_addr <= idx_w[AW-1:0];
              state   <= ST_RD_ADDR;
            end else begin
              res_value <= '0;
              res_unwr  <= 1'b1;
              state     <= ST_PUT;
            end
          end
        end
        ST_LOAD: begin
          if (rng_done) begin
            count <= count + CW'(1);
            if (rng_value < min_range) min_range <= rng_value;
            if (rng_value > max_range) max_range <= rng_value;
            state <= ST_IDLE;
          end
        end
        ST_RD_ADDR: begin
          state <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          res_unwr <= 1'b0;
          if (!fit_mode) begin
            res_value <= plain_prod[SUM_W-1:FRAC_W];
            state     <= ST_PUT;
          end else if (div_start) begin
            state <= ST_DIV_WAIT;
          end else begin
            if ((max_range > min_range) && (rd_data >= max_range)) begin
              res_value <= PIX_W'(FIT_FULL);
            end else begin
              res_value <= '0;
            end
            state <= ST_PUT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_value <= PIX_W'(div_quo);
            state     <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (put_ok) begin
            out_valid <= 1'b1;
            out_value <= res_value;
            out_unwr  <= res_unwr;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/prin_checker.sv =====
// Port-level checks for the point range image normalizer, bound to the top.
// Depends on prin_pkg.
module prin_checker import prin_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_mode,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [PIX_W-1:0] rsp_pixel_value,
  input logic             rsp_index_unwritten
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_index_unwritten |-> rsp_pixel_value == '0)
    else $error("unwritten index with nonzero pixel");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_mode && !rsp_valid |=> !rsp_valid)
    else $error("load item produced a result");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode |=> !req_ready)
    else $error("ready right after a read item");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value) &&
                                $stable(rsp_index_unwritten))
    else $error("stalled result changed");

endmodule

bind point_range_image_normalizer prin_checker u_prin_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_mode            (req.mode),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_pixel_value     (rsp.pixel_value),
  .rsp_index_unwritten (rsp.index_unwritten)
);

// ===== dv/prin_pixel_checker.sv =====
// Checker for the point range image normalizer: watches the request, response and
// register write ports, predicts each pixel result and compares it field by field.
// Depends on prin_pkg, prin_in_if and prin_out_if.
`timescale 1ns / 1ps
module prin_pixel_checker import prin_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  prin_in_if                 req,
  prin_out_if                rsp,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [SCALE_W-1:0] cfg_data,
  output int                 pending,
  output int                 fails,
  output int                 loads_seen,
  output int                 drops_seen,
  output int                 reads_seen,
  output int                 unwritten_seen
);

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             unwritten;
  } pixel_t;

  pixel_t             pending_pixels[$];
  logic [RANGE_W-1:0] frame_mem [MAX_POINTS];
  int unsigned        frame_count;
  logic [RANGE_W-1:0] frame_min;
  logic [RANGE_W-1:0] frame_max;
  logic               fit_en;
  logic [SCALE_W-1:0] scale;
  int                 fail_cnt;
  int                 load_cnt;
  int                 drop_cnt;
  int                 read_cnt;
  int                 unwritten_cnt;

  function automatic logic [RANGE_W-1:0] point_range(logic signed [COORD_W-1:0] x,
                                                     logic signed [COORD_W-1:0] y,
                                                     logic signed [COORD_W-1:0] z);
    longint             sum;
    logic [RANGE_W-1:0] root;
    logic [RANGE_W-1:0] trial;
    sum  = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
    root = '0;
    for (int b = RANGE_W - 1; b >= 0; b--) begin
      trial = root | RANGE_W'(1 << b);
      if (longint'(trial) * longint'(trial) <= sum)
        root = trial;
    end
    return root;
  endfunction

  function automatic pixel_t scaled_pixel(logic [INDEX_W-1:0] idx);
    pixel_t p;
    longint r;
    longint lo;
    longint hi;
    p.value     = '0;
    p.unwritten = 1'b1;
    if (idx < frame_count) begin
      r           = longint'(frame_mem[idx]);
      lo          = longint'(frame_min);
      hi          = longint'(frame_max);
      p.unwritten = 1'b0;
      if (fit_en) begin
        if (hi > lo) begin
          if (r <= lo)
            p.value = '0;
          else if (r >= hi)
            p.value = PIX_W'(FIT_FULL);
          else
            p.value = PIX_W'(((r - lo) * longint'(FIT_FULL)) / (hi - lo));
        end
      end else begin
        p.value = PIX_W'((r * longint'(scale)) >> FRAC_W);
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t             exp_pix;
    logic [RANGE_W-1:0] r;
    if (rst) begin
      pending_pixels.delete();
      frame_count = 0;
      frame_min   = MIN_RESET;
      frame_max   = '0;
      fit_en      = 1'b0;
      scale       = SCALE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_MODE: fit_en = cfg_data[0];
          CFG_SCALE:    scale  = cfg_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_pixels.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected pixel result value %0d unwritten %0b", $time,
                   rsp.pixel_value, rsp.index_unwritten);
        end else begin
          exp_pix = pending_pixels.pop_front();
          read_cnt++;
          if (exp_pix.unwritten)
            unwritten_cnt++;
          if (rsp.pixel_value !== exp_pix.value) begin
            fail_cnt++;
            $display("%0t: pixel_value expected %0d got %0d", $time, exp_pix.value,
                     rsp.pixel_value);
          end
          if (rsp.index_unwritten !== exp_pix.unwritten) begin
            fail_cnt++;
            $display("%0t: index_unwritten expected %0b got %0b", $time,
                     exp_pix.unwritten, rsp.index_unwritten);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (!req.mode) begin
          load_cnt++;
          if (req.first_point) begin
            frame_count = 0;
            frame_min   = MIN_RESET;
            frame_max   = '0;
          end
          if (frame_count >= MAX_POINTS) begin
            drop_cnt++;
          end else begin
            r = req.point_invalid ? '0 : point_range(req.x_coord, req.y_coord, req.z_coord);
            frame_mem[frame_count] = r;
            frame_count++;
            if (r < frame_min)
              frame_min = r;
            if (r > frame_max)
              frame_max = r;
          end
        end else begin
          pending_pixels.push_back(scaled_pixel(req.pixel_index));
        end
      end
    end
    pending        <= pending_pixels.size();
    fails          <= fail_cnt;
    loads_seen     <= load_cnt;
    drops_seen     <= drop_cnt;
    reads_seen     <= read_cnt;
    unwritten_seen <= unwritten_cnt;
  end

endmodule

// ===== dv/tb_point_range_image_normalizer.sv =====
// Testbench top for the point range image normalizer: directed and random point
// frames and pixel reads under varied idling, with a checker alongside the block.
// Depends on prin_pkg, prin_in_if, prin_out_if, point_range_image_normalizer, prin_pixel_checker.
`timescale 1ns / 1ps
module tb_point_range_image_normalizer;
  import prin_pkg::*;

  localparam int FRAME_POINTS = 64;
  localparam int SETTLE       = 30;
  localparam int PHASE_ITEMS  = 100;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [SCALE_W-1:0] cfg_data;

  int in_idle_pct;
  int out_stall_pct;
  int hold_cycles;
  int tb_count;
  int items_sent;

  int pending;
  int fails;
  int loads_seen;
  int drops_seen;
  int reads_seen;
  int unwritten_seen;

  prin_in_if  req_if ();
  prin_out_if rsp_if ();

  point_range_image_normalizer #(.MAX_POINTS(FRAME_POINTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  prin_pixel_checker #(.MAX_POINTS(FRAME_POINTS)) pixel_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req_if),
    .rsp            (rsp_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .fails          (fails),
    .loads_seen     (loads_seen),
    .drops_seen     (drops_seen),
    .reads_seen     (reads_seen),
    .unwritten_seen (unwritten_seen)
  );

  always #5 clk = ~clk;

  // response side: random stalls plus an optional long hold-off
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles  <= hold_cycles - 1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic md, logic first, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic inv,
                           logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= md;
    req_if.first_point   <= first;
    req_if.x_coord       <= x;
    req_if.y_coord       <= y;
    req_if.z_coord       <= z;
    req_if.point_invalid <= inv;
    req_if.pixel_index   <= idx;
    do @(posedge clk); while (!req_if.ready);
    if (!md)
      tb_count = first ? 1 : (tb_count < FRAME_POINTS ? tb_count + 1 : tb_count);
    items_sent++;
  endtask

  task automatic load_point(logic first, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic inv);
    send_item(1'b0, first, x, y, z, inv, INDEX_W'($urandom));
  endtask

  task automatic read_pixel(logic [INDEX_W-1:0] idx);
    send_item(1'b1, 1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), 1'($urandom), idx);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic fit, logic [SCALE_W-1:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_data  <= SCALE_W'(fit);
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'(int'($urandom_range(200)) - 100);
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return COORD_W'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] rand_index();
    case ($urandom_range(9))
      0:       return INDEX_W'($urandom);
      1:       return INDEX_W'(tb_count + int'($urandom_range(3)));
      default: return (tb_count > 0) ? INDEX_W'($urandom_range(tb_count - 1))
                                     : INDEX_W'($urandom_range(3));
    endcase
  endfunction

  // a frame of loads with reads mixed in; a stray first_point now and then
  task automatic run_frame(int n_loads, int n_reads);
    int loads_left;
    int reads_left;
    logic first;
    loads_left = n_loads;
    reads_left = n_reads;
    while (loads_left + reads_left > 0) begin
      if (loads_left > 0 && (reads_left == 0 || $urandom_range(3) != 0)) begin
        first = (loads_left == n_loads) || ($urandom_range(49) == 0);
        load_point(first, rand_coord(), rand_coord(), rand_coord(), $urandom_range(9) == 0);
        loads_left--;
      end else begin
        read_pixel(rand_index());
        reads_left--;
      end
    end
  endtask

  initial begin
    int phase_start;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_FIT_MODE;
    cfg_data             <= '0;
    req_if.valid         <= 1'b0;
    req_if.mode          <= 1'b0;
    req_if.first_point   <= 1'b0;
    req_if.x_coord       <= '0;
    req_if.y_coord       <= '0;
    req_if.z_coord       <= '0;
    req_if.point_invalid <= 1'b0;
    req_if.pixel_index   <= '0;
    in_idle_pct          <= 0;
    out_stall_pct        <= 0;
    hold_cycles          <= 0;
    tb_count   = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // plain mode at the largest scale the bench uses
    set_regs(1'b0, 16'd64000);
    load_point(1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    load_point(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    load_point(1'b0, 16'h1234, 16'hedcb, 16'h7fff, 1'b1);
    load_point(1'b0, 16'd3, 16'hfffc, 16'd0, 1'b0);
    load_point(1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
    for (int i = 0; i < 6; i++)
      read_pixel(INDEX_W'(i));
    read_pixel(16'hffff);
    wait_idle();

    // fit mode over the same frame, then a flat frame
    set_regs(1'b1, 16'd64);
    read_pixel(16'd0);
    read_pixel(16'd1);
    read_pixel(16'd3);
    read_pixel(16'd4);
    load_point(1'b1, 16'd5, 16'd0, 16'd0, 1'b0);
    load_point(1'b0, 16'd0, 16'hfffb, 16'd0, 1'b0);
    read_pixel(16'd0);
    read_pixel(16'd1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          set_regs(1'b0, 16'd64);
          in_idle_pct   <= 0;
          out_stall_pct <= 0;
        end
        1: begin
          set_regs(1'b1, SCALE_W'($urandom_range(64, 64000)));
          in_idle_pct   <= 82;
          out_stall_pct <= 0;
        end
        2: begin
          set_regs(1'b0, 16'd64000);
          in_idle_pct   <= 0;
          out_stall_pct <= 82;
        end
        default: begin
          set_regs(1'($urandom_range(1)), SCALE_W'($urandom_range(64, 64000)));
          in_idle_pct   <= 20;
          out_stall_pct <= 20;
        end
      endcase
      phase_start = items_sent;
      if (ph == 0) begin
        // receiver holds off while reads keep coming
        hold_cycles <= 400;
        run_frame(8, 20);
      end
      if (ph == 1)
        run_frame(FRAME_POINTS + 6, 10);
      while (items_sent - phase_start < PHASE_ITEMS)
        run_frame($urandom_range(1, 16), $urandom_range(1, 12));
    end

    wait_idle();
    $display("Covered %0d point loads (%0d dropped on a full store) and %0d pixel reads",
             loads_seen, drops_seen, reads_seen);
    $display("(%0d of unwritten indexes) in plain and fit modes under four idling patterns.",
             unwritten_seen);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== point_range_image_normalizer.f =====
rtl/prin_pkg.sv
rtl/prin_in_if.sv
rtl/prin_out_if.sv
rtl/prin_range.sv
rtl/prin_div.sv
rtl/point_range_image_normalizer.sv
rtl/prin_checker.sv
dv/prin_pixel_checker.sv
dv/tb_point_range_image_normalizer.sv
